[src/sfr_pkg.sv]
`timescale 1ns / 1ps

package sfr_pkg;

  // sizes of the window, pattern and replacement
  localparam int PATTERN_MAX = 16;
  localparam int REPLACE_MAX = 16;
  localparam int WIN_DEPTH   = 16;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_SEL_W   = 3;
  localparam int STR_W       = WIN_DEPTH * CHAR_W;

  // register indexes (byte address is 8 times the index)
  localparam logic [REG_SEL_W-1:0] REG_PAT_LO  = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_PAT_HI  = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_PAT_LEN = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_REP_LO  = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_REP_HI  = 3'd4;
  localparam logic [REG_SEL_W-1:0] REG_REP_LEN = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPL,
    ST_WIN,
    ST_MARK
  } sfr_state_t;

  // configuration as seen by the datapath, lengths already clamped
  typedef struct packed {
    logic [STR_W-1:0] pat;
    logic [STR_W-1:0] rep;
    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
  } sfr_cfg_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
  } sfr_cell_ctl_t;

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v, logic [LEN_W-1:0] cap);
    logic [LEN_W-1:0] r;
    r = (v > cap) ? cap : v;
    return r;
  endfunction

endpackage

[src/sfr_cell.sv]
`timescale 1ns / 1ps

module sfr_cell import sfr_pkg::*; (
  input  logic              clk,
  input  sfr_cell_ctl_t     ctl,
  input  logic [CHAR_W-1:0] load_char,
  input  logic [CHAR_W-1:0] next_char,
  input  logic [CHAR_W-1:0] pat_char,
  input  logic              in_use,
  output logic [CHAR_W-1:0] char_q,
  output logic              eq
);

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;
  logic [CHAR_W-1:0] eff_char;

  // value this cell holds once the incoming character is placed
  assign eff_char = ctl.load ? load_char : char_r;

  // cells beyond the pattern length always agree
  assign eq = !in_use || (eff_char == pat_char);

  // load a new character or take the neighbour's on a pop
  always_comb begin
    char_nxt = char_r;
    if (ctl.load) begin
      char_nxt = load_char;
    end else if (ctl.shift) begin
      char_nxt = next_char;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule

[src/sfr_regs.sv]
`timescale 1ns / 1ps

module sfr_regs import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sfr_cfg_t          cfg,
  output logic              plen_wr
);

  logic [DATA_W-1:0]    pat_lo_r, pat_hi_r, rep_lo_r, rep_hi_r;
  logic [LEN_W-1:0]     plen_r, rlen_r;
  logic [REG_SEL_W-1:0] sel;
  logic                 wr_en;

  assign pready = 1'b1;
  assign sel    = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;

  // write side, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      rep_lo_r <= '0;
      rep_hi_r <= '0;
      plen_r   <= '0;
      rlen_r   <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_PAT_LO:  pat_lo_r <= pwdata;
        REG_PAT_HI:  pat_hi_r <= pwdata;
        REG_PAT_LEN: plen_r   <= pwdata[LEN_W-1:0];
        REG_REP_LO:  rep_lo_r <= pwdata;
        REG_REP_HI:  rep_hi_r <= pwdata;
        REG_REP_LEN: rlen_r   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // a new pattern length throws away the pending window
  assign plen_wr = wr_en && (sel == REG_PAT_LEN);

  // read side
  always_comb begin
    unique case (sel)
      REG_PAT_LO:  prdata = pat_lo_r;
      REG_PAT_HI:  prdata = pat_hi_r;
      REG_PAT_LEN: prdata = DATA_W'(plen_r);
      REG_REP_LO:  prdata = rep_lo_r;
      REG_REP_HI:  prdata = rep_hi_r;
      REG_REP_LEN: prdata = DATA_W'(rlen_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.pat  = {pat_hi_r, pat_lo_r};
  assign cfg.rep  = {rep_hi_r, rep_lo_r};
  assign cfg.plen = clamp_len(plen_r, LEN_W'(PATTERN_MAX));
  assign cfg.rlen = clamp_len(rlen_r, LEN_W'(REPLACE_MAX));

endmodule

[src/stream_find_replace.sv]
`timescale 1ns / 1ps

// Streaming find-and-replace over 8-bit characters. Pending characters sit in a
// row of 16 cells, each comparing its character with its pattern byte, so a
// match is decided in the cycle a character is accepted. Each accepted item is
// followed by the results it causes (a replacement burst, popped window
// characters, a flush, or the empty end marker): in_stall is held high while
// those results are issued, one a cycle through a single output register, and
// longer if out_stall holds that register. An item causing no result leaves
// in_stall low. There is no clearing pass after reset.

module stream_find_replace import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input requests
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_has_char,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_is_last,
  // result requests
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_char_valid,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_of_run,
  output logic              out_stream_done,
  output logic              out_match_seen,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  sfr_cfg_t   cfg;
  logic       plen_wr;
  sfr_state_t state_r, state_nxt;

  logic [LEN_W-1:0] wc_r, wc_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] rep_idx_r, rep_idx_nxt;
  logic             seen_r, seen_nxt;
  logic             job_last_r, job_last_nxt;
  logic             job_seen_r, job_seen_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_cv_r, out_cv_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_lor_r, out_lor_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_seen_r, out_seen_nxt;

  logic acc, adv, shift_en;

  logic [CHAR_W-1:0] cell_char [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] cell_eq;

  logic [LEN_W-1:0] wcw, wc1;
  logic             is_cmp, is_match, seen_new;
  sfr_state_t       dec_state;
  logic [LEN_W-1:0] dec_cnt, dec_wc;
  logic [CHAR_W-1:0] rep_char;

  sfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .plen_wr (plen_wr)
  );

  // handshakes
  assign in_stall = (state_r != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign adv      = !out_valid_r || !out_stall;

  // slot for the incoming character
  assign wcw = (wc_r >= cfg.plen) ? '0 : wc_r;
  assign wc1 = wcw + LEN_W'(1);

  // row of window cells
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    sfr_cell_ctl_t     ctl;
    logic [CHAR_W-1:0] next_char;

    assign ctl.load  = acc && in_has_char && (wcw == LEN_W'(i));
    assign ctl.shift = shift_en;
    assign next_char = (i == WIN_DEPTH - 1) ? cell_char[i] : cell_char[(i + 1) % WIN_DEPTH];

    sfr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_char (in_char),
      .next_char (next_char),
      .pat_char  (cfg.pat[i*CHAR_W +: CHAR_W]),
      .in_use    (LEN_W'(i) < cfg.plen),
      .char_q    (cell_char[i]),
      .eq        (cell_eq[i])
    );
  end

  // decide the job an accepted item starts
  assign is_cmp   = in_has_char && (cfg.plen != '0) && (wc1 == cfg.plen);
  assign is_match = is_cmp && (&cell_eq);
  assign seen_new = seen_r || is_match;

  always_comb begin
    dec_state = ST_IDLE;
    dec_cnt   = '0;
    dec_wc    = wc_r;
    priority if (in_has_char && (cfg.plen == '0)) begin
      dec_state = ST_WIN;
      dec_cnt   = LEN_W'(1);
      dec_wc    = '0;
    end else if (is_match) begin
      dec_state = (cfg.rlen != '0) ? ST_REPL : (in_is_last ? ST_MARK : ST_IDLE);
      dec_cnt   = cfg.rlen;
      dec_wc    = '0;
    end else if (is_cmp) begin
      dec_state = ST_WIN;
      dec_cnt   = in_is_last ? cfg.plen : LEN_W'(1);
      dec_wc    = in_is_last ? '0 : cfg.plen - LEN_W'(1);
    end else if (in_has_char) begin
      dec_state = in_is_last ? ST_WIN : ST_IDLE;
      dec_cnt   = in_is_last ? wc1 : '0;
      dec_wc    = in_is_last ? '0 : wc1;
    end else if (in_is_last) begin
      dec_state = (wc_r != '0) ? ST_WIN : ST_MARK;
      dec_cnt   = wc_r;
      dec_wc    = '0;
    end else begin
      // idle item leaves everything as it is
      dec_wc    = wc_r;
    end
  end

  assign rep_char = cfg.rep[{rep_idx_r, 3'b000} +: CHAR_W];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = dec_state;
      end
      ST_REPL, ST_WIN: begin
        if (adv && (cnt_r == LEN_W'(1))) state_nxt = ST_IDLE;
      end
      ST_MARK: begin
        if (adv) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    cnt_nxt       = cnt_r;
    rep_idx_nxt   = rep_idx_r;
    wc_nxt        = wc_r;
    seen_nxt      = seen_r;
    job_last_nxt  = job_last_r;
    job_seen_nxt  = job_seen_r;
    shift_en      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_cv_nxt    = out_cv_r;
    out_char_nxt  = out_char_r;
    out_lor_nxt   = out_lor_r;
    out_done_nxt  = out_done_r;
    out_seen_nxt  = out_seen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cnt_nxt      = dec_cnt;
          rep_idx_nxt  = '0;
          wc_nxt       = dec_wc;
          job_last_nxt = in_is_last;
          job_seen_nxt = seen_new;
          seen_nxt     = in_is_last ? 1'b0 : seen_new;
        end
      end
      ST_REPL: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_cv_nxt    = 1'b1;
          out_char_nxt  = rep_char;
          out_lor_nxt   = (cnt_r == LEN_W'(1));
          out_done_nxt  = job_last_r && (cnt_r == LEN_W'(1));
          out_seen_nxt  = job_seen_r;
          cnt_nxt       = cnt_r - LEN_W'(1);
          rep_idx_nxt   = rep_idx_r + IDX_W'(1);
        end
      end
      ST_WIN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_cv_nxt    = 1'b1;
          out_char_nxt  = cell_char[0];
          out_lor_nxt   = (cnt_r == LEN_W'(1));
          out_done_nxt  = job_last_r && (cnt_r == LEN_W'(1));
          out_seen_nxt  = job_seen_r;
          cnt_nxt       = cnt_r - LEN_W'(1);
          shift_en      = 1'b1;
        end
      end
      ST_MARK: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_cv_nxt    = 1'b0;
          out_char_nxt  = '0;
          out_lor_nxt   = 1'b1;
          out_done_nxt  = job_last_r;
          out_seen_nxt  = job_seen_r;
        end
      end
      default: ;
    endcase
    // pattern length rewrite empties the window
    if (plen_wr) wc_nxt = '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= '0;
      cnt_r       <= '0;
      rep_idx_r   <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      cnt_r       <= cnt_nxt;
      rep_idx_r   <= rep_idx_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    job_last_r <= job_last_nxt;
    job_seen_r <= job_seen_nxt;
    out_cv_r   <= out_cv_nxt;
    out_char_r <= out_char_nxt;
    out_lor_r  <= out_lor_nxt;
    out_done_r <= out_done_nxt;
    out_seen_r <= out_seen_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = out_cv_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_lor_r;
  assign out_stream_done = out_done_r;
  assign out_match_seen  = out_seen_r;

  // pending window always shorter than the pattern
  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wc_r == '0) || (wc_r < cfg.plen))
    else $error("window count not below pattern length");

  // an emitting state always has results left
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_WIN) || (state_r == ST_REPL)) |-> (cnt_r != '0))
    else $error("emitting with no results left");

  // end of string only on the last result of a request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_lor_r)
    else $error("stream done without last of run");

  // end marker carries a zero character
  a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_cv_r) |-> ((out_char_r == '0) && out_lor_r))
    else $error("empty result malformed");

  // sticky flag cleared once a string ends
  a_seen_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_is_last) |=> !seen_r)
    else $error("match flag survived end of string");

endmodule
